// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and register codes for the spring distance constraint block.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREAKING_ENABLED = 3'd4;

  typedef struct packed {
    logic advance;
    logic vld;
  } pipe_ctrl_t;

endpackage

// ===== rtl/sdc_sqrt.sv =====
// ----------------------------------------------------------------------------
// sdc_sqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module sdc_sqrt #(
  parameter int RW = 33,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  sdc_pkg::pipe_ctrl_t ctrl,
  input  logic [2*RW-1:0]     rad,
  input  logic [SW-1:0]       side_in,
  output logic                out_vld,
  output logic [RW-1:0]       root,
  output logic [SW-1:0]       side_out
);
  import sdc_pkg::*;

  localparam int NW = 2 * RW;

  logic [NW-1:0] rem_r  [RW-1];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];
  logic          vld_r  [RW];

  logic [NW-1:0] in_rem   [RW];
  logic [RW-1:0] in_root  [RW];
  logic [NW-1:0] trial    [RW];
  logic [NW-1:0] nxt_rem  [RW];
  logic [RW-1:0] nxt_root [RW];

  always_comb begin
    in_rem[0]  = rad;
    in_root[0] = '0;
    for (int k = 1; k < RW; k++) begin
      in_rem[k]  = rem_r[k-1];
      in_root[k] = root_r[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      trial[k] = (NW'(in_root[k]) << (RW - k)) + (NW'(1) << (2 * (RW - 1 - k)));
      if (in_rem[k] >= trial[k]) begin
        nxt_rem[k]  = in_rem[k] - trial[k];
        nxt_root[k] = in_root[k] | (RW'(1) << (RW - 1 - k));
      end else begin
        nxt_rem[k]  = in_rem[k];
        nxt_root[k] = in_root[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) vld_r[k] <= 1'b0;
    end else if (ctrl.advance) begin
      vld_r[0] <= ctrl.vld;
      for (int k = 1; k < RW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      side_r[0] <= side_in;
      for (int k = 1; k < RW; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < RW; k++) root_r[k] <= nxt_root[k];
      for (int k = 0; k < RW - 1; k++) rem_r[k] <= nxt_rem[k];
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign root     = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

// ===== rtl/sdc_div.sv =====
// ----------------------------------------------------------------------------
// sdc_div
// Pipelined restoring divider, one quotient bit per stage, N lanes sharing
// one divisor, with side payload.
// ----------------------------------------------------------------------------
module sdc_div #(
  parameter int N  = 2,
  parameter int NW = 66,
  parameter int DW = 33,
  parameter int QW = 33,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sdc_pkg::pipe_ctrl_t    ctrl,
  input  logic [N-1:0][NW-1:0]   num,
  input  logic [DW-1:0]          den,
  input  logic [SW-1:0]          side_in,
  output logic                   out_vld,
  output logic [N-1:0][QW-1:0]   quo,
  output logic [SW-1:0]          side_out
);
  import sdc_pkg::*;

  logic [N-1:0][NW-1:0] rem_r [QW-1];
  logic [DW-1:0]        den_r [QW-1];
  logic [N-1:0][QW-1:0] quo_r [QW];
  logic [SW-1:0]        side_r [QW];
  logic                 vld_r [QW];

  logic [N-1:0][NW-1:0] in_rem  [QW];
  logic [N-1:0][QW-1:0] in_quo  [QW];
  logic [DW-1:0]        in_den  [QW];
  logic [N-1:0][NW-1:0] nxt_rem [QW];
  logic [N-1:0][QW-1:0] nxt_quo [QW];

  always_comb begin
    logic [NW-1:0] sub;
    in_rem[0] = num;
    in_quo[0] = '0;
    in_den[0] = den;
    for (int k = 1; k < QW; k++) begin
      in_rem[k] = rem_r[k-1];
      in_quo[k] = quo_r[k-1];
      in_den[k] = den_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      sub = NW'(in_den[k]) << (QW - 1 - k);
      for (int n = 0; n < N; n++) begin
        if (in_rem[k][n] >= sub) begin
          nxt_rem[k][n] = in_rem[k][n] - sub;
          nxt_quo[k][n] = in_quo[k][n] | (QW'(1) << (QW - 1 - k));
        end else begin
          nxt_rem[k][n] = in_rem[k][n];
          nxt_quo[k][n] = in_quo[k][n];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) vld_r[k] <= 1'b0;
    end else if (ctrl.advance) begin
      vld_r[0] <= ctrl.vld;
      for (int k = 1; k < QW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      side_r[0] <= side_in;
      for (int k = 1; k < QW; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < QW; k++) quo_r[k] <= nxt_quo[k];
      for (int k = 0; k < QW - 1; k++) begin
        rem_r[k] <= nxt_rem[k];
        den_r[k] <= in_den[k];
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== rtl/spring_distance_constraint.sv =====
// ----------------------------------------------------------------------------
// spring_distance_constraint
// Fixed-point distance constraint between two bodies in the plane.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled, and it
// returns one word per input word, in order: the square root and both divider
// banks each resolve one bit per stage, and eight more register stages hold the
// squares, products and output. A stall on the output freezes the whole
// pipeline, so no word is lost or repeated.
module spring_distance_constraint #(
  parameter int  COORD_WIDTH = 32,
  parameter int  FRAC_BITS   = 16,
  localparam int IN_W        = ((6 * COORD_WIDTH - 2 + 7) / 8) * 8,
  localparam int OUT_W       = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFG_W       = (COORD_WIDTH - 1 > FRAC_BITS) ? COORD_WIDTH - 1 : FRAC_BITS + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b
  input  logic [IN_W-1:0]                s_tdata,
  // fixed_a, fixed_b
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drag_a_x, drag_a_y, drag_b_x, drag_b_y
  output logic [OUT_W-1:0]               m_tdata,
  // spring_broken
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_wen,
  input  logic [sdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);
  import sdc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = W - 1;
  localparam int VW  = W + 1;
  localparam int SQW = 2 * VW;
  localparam int PW2 = VW + MW;
  localparam int SW1 = 2 * VW + 2 + 2 * MW + 2;
  localparam int SW2 = 4 + 2 * MW + 2;
  localparam int SW3 = 2 * VW + 6;

  logic [MW-1:0] rest_length;
  logic [F:0]    damping_gain;
  logic [MW-1:0] max_length;
  logic [MW-1:0] min_length;
  logic          breaking_enabled;
  logic          broken_flag;

  logic [F:0]    gain_c;
  logic          adv;

  function automatic logic [W-1:0] sat(input logic [VW-1:0] m, input logic neg);
    logic [VW-1:0] lim;
    logic [VW-1:0] mm;
    lim = neg ? (VW'(1) << (W - 1)) : (VW'(1) << (W - 1)) - VW'(1);
    mm  = (m > lim) ? lim : m;
    return neg ? W'(VW'(0) - mm) : W'(mm);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length      <= MW'(65536);
      damping_gain     <= (F + 1)'(32768);
      max_length       <= '1;
      min_length       <= '0;
      breaking_enabled <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_REST_LENGTH:      rest_length      <= MW'(cfg_data);
        REG_DAMPING_GAIN:     damping_gain     <= (F + 1)'(cfg_data);
        REG_MAX_LENGTH:       max_length       <= MW'(cfg_data);
        REG_MIN_LENGTH:       min_length       <= MW'(cfg_data);
        REG_BREAKING_ENABLED: breaking_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign gain_c   = (damping_gain > ((F + 1)'(1) << F)) ? ((F + 1)'(1) << F) : damping_gain;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: differences and magnitudes
  logic [W:0]    dx, dy;
  logic          v1, neg0_1, neg1_1, fa_1, fb_1;
  logic [VW-1:0] mag0_1, mag1_1;
  logic [MW-1:0] ma_1, mb_1;

  assign dx = {s_tdata[W-1], s_tdata[W-1:0]} - {s_tdata[3*W-1], s_tdata[3*W-1:2*W]};
  assign dy = {s_tdata[2*W-1], s_tdata[2*W-1:W]} - {s_tdata[4*W-1], s_tdata[4*W-1:3*W]};

  // stage 2: squares; stage 3: sum of squares
  logic          v2, v3;
  logic [SQW-1:0] sq0_2, sq1_2, rad_3;
  logic [SW1-1:0] side_2, side_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg0_1 <= dx[W];
      neg1_1 <= dy[W];
      mag0_1 <= dx[W] ? VW'(-dx) : VW'(dx);
      mag1_1 <= dy[W] ? VW'(-dy) : VW'(dy);
      ma_1   <= s_tdata[4*W +: MW];
      mb_1   <= s_tdata[4*W+MW +: MW];
      fa_1   <= s_tuser[0];
      fb_1   <= s_tuser[1];
      sq0_2  <= SQW'(mag0_1) * SQW'(mag0_1);
      sq1_2  <= SQW'(mag1_1) * SQW'(mag1_1);
      side_2 <= {mag0_1, mag1_1, neg0_1, neg1_1, ma_1, mb_1, fa_1, fb_1};
      rad_3  <= sq0_2 + sq1_2;
      side_3 <= side_2;
    end
  end

  pipe_ctrl_t     c_sq;
  logic           v_sq;
  logic [VW-1:0]  d_sq;
  logic [SW1-1:0] side_sq;

  assign c_sq = '{advance: adv, vld: v3};

  sdc_sqrt #(.RW(VW), .SW(SW1)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (c_sq),
    .rad      (rad_3),
    .side_in  (side_3),
    .out_vld  (v_sq),
    .root     (d_sq),
    .side_out (side_sq)
  );

  // stage 4: stretch, break check; stage 5: numerators
  logic [VW-1:0] mag0_s, mag1_s;
  logic          neg0_s, neg1_s, fa_s, fb_s;
  logic [MW-1:0] ma_s, mb_s;
  logic          rneg, brk_hit, brk_now;

  assign {mag0_s, mag1_s, neg0_s, neg1_s, ma_s, mb_s, fa_s, fb_s} = side_sq;
  assign rneg    = d_sq < VW'(rest_length);
  assign brk_hit = breaking_enabled &&
                   (d_sq > VW'(max_length) || d_sq < VW'(min_length));
  assign brk_now = broken_flag || brk_hit;

  logic          v4, v5;
  logic [VW-1:0] d_4, dr_4, mag0_4, mag1_4, d_5;
  logic [SQW-1:0] p0_5, p1_5;
  logic [SW2-1:0] side_4, side_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      broken_flag <= 1'b0;
      v4          <= 1'b0;
      v5          <= 1'b0;
    end else if (adv) begin
      if (v_sq) broken_flag <= brk_now;
      v4 <= v_sq;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_4    <= d_sq;
      dr_4   <= rneg ? VW'(rest_length) - d_sq : d_sq - VW'(rest_length);
      mag0_4 <= mag0_s;
      mag1_4 <= mag1_s;
      side_4 <= {neg0_s ^ rneg, neg1_s ^ rneg, (d_sq == '0) || (fa_s && fb_s), brk_now,
                 ma_s, mb_s, fa_s, fb_s};
      d_5    <= d_4;
      p0_5   <= SQW'(mag0_4) * SQW'(dr_4);
      p1_5   <= SQW'(mag1_4) * SQW'(dr_4);
      side_5 <= side_4;
    end
  end

  pipe_ctrl_t              c_d1;
  logic                    v_d1;
  logic [1:0][VW-1:0]      q_d1;
  logic [SW2-1:0]          side_d1;

  assign c_d1 = '{advance: adv, vld: v5};

  sdc_div #(.N(2), .NW(SQW), .DW(VW), .QW(VW), .SW(SW2)) u_div_stretch (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (c_d1),
    .num      ({p1_5, p0_5}),
    .den      (d_5),
    .side_in  (side_5),
    .out_vld  (v_d1),
    .quo      (q_d1),
    .side_out (side_d1)
  );

  // stage 6: gain; stage 7: mass products
  logic          s0_q, s1_q, zero_q, brk_q, fa_q, fb_q;
  logic [MW-1:0] ma_q, mb_q;

  assign {s0_q, s1_q, zero_q, brk_q, ma_q, mb_q, fa_q, fb_q} = side_d1;

  logic             v6, v7;
  logic [VW+F:0]    g0_6, g1_6;
  logic [W-1:0]     tot_6, tot_7;
  logic [MW-1:0]    ma_6, mb_6;
  logic             s0_6, s1_6, zero_6, brk_6, fa_6, fb_6;
  logic [VW-1:0]    disp0, disp1;
  logic [3:0][PW2-1:0] pm_7;
  logic [SW3-1:0]   side_7;

  assign disp0 = VW'(g0_6 >> F);
  assign disp1 = VW'(g1_6 >> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v6 <= v_d1;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g0_6    <= (VW + F + 1)'(q_d1[0]) * (VW + F + 1)'(gain_c);
      g1_6    <= (VW + F + 1)'(q_d1[1]) * (VW + F + 1)'(gain_c);
      tot_6   <= W'(ma_q) + W'(mb_q);
      ma_6    <= ma_q;
      mb_6    <= mb_q;
      s0_6    <= s0_q;
      s1_6    <= s1_q;
      zero_6  <= zero_q;
      brk_6   <= brk_q;
      fa_6    <= fa_q;
      fb_6    <= fb_q;
      pm_7[0] <= PW2'(disp0) * PW2'(mb_6);
      pm_7[1] <= PW2'(disp1) * PW2'(mb_6);
      pm_7[2] <= PW2'(disp0) * PW2'(ma_6);
      pm_7[3] <= PW2'(disp1) * PW2'(ma_6);
      tot_7   <= tot_6;
      side_7  <= {disp0, disp1, s0_6, s1_6,
                  zero_6 || (!fa_6 && !fb_6 && tot_6 == '0), brk_6, fa_6, fb_6};
    end
  end

  pipe_ctrl_t          c_d2;
  logic                v_d2;
  logic [3:0][VW-1:0]  q_d2;
  logic [SW3-1:0]      side_d2;

  assign c_d2 = '{advance: adv, vld: v7};

  sdc_div #(.N(4), .NW(PW2), .DW(W), .QW(VW), .SW(SW3)) u_div_mass (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (c_d2),
    .num      (pm_7),
    .den      (tot_7),
    .side_in  (side_7),
    .out_vld  (v_d2),
    .quo      (q_d2),
    .side_out (side_d2)
  );

  // stage 8: select and saturate
  logic [VW-1:0] disp0_o, disp1_o;
  logic          s0_o, s1_o, zero_o, brk_o, fa_o, fb_o;
  logic [W-1:0]  ax_next, ay_next, bx_next, by_next;
  logic [W-1:0]  drag_a_x, drag_a_y, drag_b_x, drag_b_y;
  logic          spring_broken;

  assign {disp0_o, disp1_o, s0_o, s1_o, zero_o, brk_o, fa_o, fb_o} = side_d2;

  always_comb begin
    ax_next = '0;
    ay_next = '0;
    bx_next = '0;
    by_next = '0;
    if (!zero_o) begin
      if (!fa_o && fb_o) begin
        ax_next = sat(disp0_o, !s0_o);
        ay_next = sat(disp1_o, !s1_o);
      end else if (fa_o) begin
        bx_next = sat(disp0_o, s0_o);
        by_next = sat(disp1_o, s1_o);
      end else begin
        ax_next = sat(q_d2[0], !s0_o);
        ay_next = sat(q_d2[1], !s1_o);
        bx_next = sat(q_d2[2], s0_o);
        by_next = sat(q_d2[3], s1_o);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v_d2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drag_a_x      <= ax_next;
      drag_a_y      <= ay_next;
      drag_b_x      <= bx_next;
      drag_b_y      <= by_next;
      spring_broken <= brk_o;
    end
  end

  assign m_tdata = OUT_W'({drag_b_y, drag_b_x, drag_a_y, drag_a_x});
  assign m_tuser = spring_broken;

`ifndef NO_ASSERTIONS
  a_broken_sticky: assert property (@(posedge clk) disable iff (rst)
    broken_flag |=> broken_flag)
    else $error("broken flag cleared without reset");

  a_broken_needs_enable: assert property (@(posedge clk) disable iff (rst)
    $rose(broken_flag) |-> $past(breaking_enabled))
    else $error("broken flag set while breaking disabled");

  a_report_matches_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !broken_flag) |-> !m_tuser[0])
    else $error("output word reports broken before flag is set");
`endif

endmodule
